// ===== rtl/ara_pkg.sv =====
`default_nettype none
package ara_pkg;

  // Request codes
  localparam logic [1:0] CMD_FIND = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_FREE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Datapath operations issued by the controller, one per cycle
  typedef logic [4:0] op_t;
  localparam op_t OP_IDLE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_NOTFOUND = 5'd2;
  localparam op_t OP_RD_SCAN  = 5'd3;
  localparam op_t OP_NEXT     = 5'd4;
  localparam op_t OP_FIND_HIT = 5'd5;
  localparam op_t OP_SET_FULL = 5'd6;
  localparam op_t OP_TAKE_HIT = 5'd7;
  localparam op_t OP_RD_J     = 5'd8;
  localparam op_t OP_WR_SHIFT = 5'd9;
  localparam op_t OP_WR_LEFT  = 5'd10;
  localparam op_t OP_WR_MID   = 5'd11;
  localparam op_t OP_WR_RIGHT = 5'd12;
  localparam op_t OP_FREE_HIT = 5'd13;
  localparam op_t OP_RD_LO    = 5'd14;
  localparam op_t OP_LO_DEC   = 5'd15;
  localparam op_t OP_RD_HI    = 5'd16;
  localparam op_t OP_HI_INC   = 5'd17;
  localparam op_t OP_WR_MERGE = 5'd18;
  localparam op_t OP_WR_MOVE  = 5'd19;
  localparam op_t OP_FIN_FREE = 5'd20;

  // Datapath flags seen by the controller
  typedef struct packed {
    logic early;
    logic is_find;
    logic is_take;
    logic is_free;
    logic scan_end;
    logic match;
    logic full;
    logic sh_done;
    logic left;
    logic right;
    logic lo_zero;
    logic hi_last;
    logic rd_alloc;
    logic mv_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/address_range_allocator.sv =====
`default_nettype none
// First-fit allocator over an address-ordered table of page segments held in
// a single-port-read, single-port-write memory. One request is handled at a
// time: a request scans the table segment by segment, a take that splits a
// segment moves table entries up to open a gap, and a free examines its
// neighbours and moves table entries down when it merges them. The scan and
// the entry moves share the one memory read port. in_stall is high from
// acceptance until the result beat is taken.
module address_range_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int PAGE_SHIFT   = 12,
  parameter int ADDR_BITS    = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   command,
  input  wire logic [ADDR_BITS-1:0]         address,
  input  wire logic [ADDR_BITS-PAGE_SHIFT:0] page_count,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        status,
  output logic [ADDR_BITS-1:0]              found_address,
  output logic [ADDR_BITS-PAGE_SHIFT:0]     freed_pages
);

  ara_pkg::op_t   op;
  ara_pkg::stat_t st;

  ara_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .st        (st),
    .op        (op),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  ara_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .PAGE_SHIFT   (PAGE_SHIFT),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .command       (command),
    .address       (address),
    .page_count    (page_count),
    .st            (st),
    .status        (status),
    .found_address (found_address),
    .freed_pages   (freed_pages)
  );

endmodule
`default_nettype wire

// ===== rtl/ara_ctrl.sv =====
`default_nettype none
module ara_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          out_stall,
  input  wire ara_pkg::stat_t st,
  output ara_pkg::op_t       op,
  output logic               in_stall,
  output logic               out_valid
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_CHECK   = 4'd2;
  localparam logic [3:0] S_SH_TEST = 4'd3;
  localparam logic [3:0] S_SH_WR   = 4'd4;
  localparam logic [3:0] S_WR_L    = 4'd5;
  localparam logic [3:0] S_WR_M    = 4'd6;
  localparam logic [3:0] S_WR_R    = 4'd7;
  localparam logic [3:0] S_LO_TEST = 4'd8;
  localparam logic [3:0] S_LO_CHK  = 4'd9;
  localparam logic [3:0] S_HI_TEST = 4'd10;
  localparam logic [3:0] S_HI_CHK  = 4'd11;
  localparam logic [3:0] S_MERGE   = 4'd12;
  localparam logic [3:0] S_MV_TEST = 4'd13;
  localparam logic [3:0] S_MV_WR   = 4'd14;
  localparam logic [3:0] S_RESULT  = 4'd15;

  logic [3:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_RESULT);

  // Sequence one request through scan, table update and result
  always_comb begin
    state_next = state;
    op         = ara_pkg::OP_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = ara_pkg::OP_LOAD;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.early) begin
          state_next = S_RESULT;
        end else if (st.scan_end) begin
          op         = ara_pkg::OP_NOTFOUND;
          state_next = S_RESULT;
        end else begin
          op         = ara_pkg::OP_RD_SCAN;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!st.match) begin
          op         = ara_pkg::OP_NEXT;
          state_next = S_SCAN;
        end else if (st.is_find) begin
          op         = ara_pkg::OP_FIND_HIT;
          state_next = S_RESULT;
        end else if (st.is_take) begin
          if (st.full) begin
            op         = ara_pkg::OP_SET_FULL;
            state_next = S_RESULT;
          end else begin
            op         = ara_pkg::OP_TAKE_HIT;
            state_next = S_SH_TEST;
          end
        end else begin
          op         = ara_pkg::OP_FREE_HIT;
          state_next = S_LO_TEST;
        end
      end
      S_SH_TEST: begin
        if (st.sh_done) begin
          state_next = S_WR_L;
        end else begin
          op         = ara_pkg::OP_RD_J;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        op         = ara_pkg::OP_WR_SHIFT;
        state_next = S_SH_TEST;
      end
      S_WR_L: begin
        if (st.left) begin
          op = ara_pkg::OP_WR_LEFT;
        end
        state_next = S_WR_M;
      end
      S_WR_M: begin
        op         = ara_pkg::OP_WR_MID;
        state_next = S_WR_R;
      end
      S_WR_R: begin
        if (st.right) begin
          op = ara_pkg::OP_WR_RIGHT;
        end
        state_next = S_RESULT;
      end
      S_LO_TEST: begin
        if (st.lo_zero) begin
          state_next = S_HI_TEST;
        end else begin
          op         = ara_pkg::OP_RD_LO;
          state_next = S_LO_CHK;
        end
      end
      S_LO_CHK: begin
        if (!st.rd_alloc) begin
          op         = ara_pkg::OP_LO_DEC;
          state_next = S_LO_TEST;
        end else begin
          state_next = S_HI_TEST;
        end
      end
      S_HI_TEST: begin
        if (st.hi_last) begin
          state_next = S_MERGE;
        end else begin
          op         = ara_pkg::OP_RD_HI;
          state_next = S_HI_CHK;
        end
      end
      S_HI_CHK: begin
        if (!st.rd_alloc) begin
          op         = ara_pkg::OP_HI_INC;
          state_next = S_HI_TEST;
        end else begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        op         = ara_pkg::OP_WR_MERGE;
        state_next = S_MV_TEST;
      end
      S_MV_TEST: begin
        if (st.mv_done) begin
          op         = ara_pkg::OP_FIN_FREE;
          state_next = S_RESULT;
        end else begin
          op         = ara_pkg::OP_RD_J;
          state_next = S_MV_WR;
        end
      end
      S_MV_WR: begin
        op         = ara_pkg::OP_WR_MOVE;
        state_next = S_MV_TEST;
      end
      S_RESULT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ara_dp.sv =====
`default_nettype none
module ara_dp #(
  parameter int MAX_SEGMENTS = 64,
  parameter int PAGE_SHIFT   = 12,
  parameter int ADDR_BITS    = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ara_pkg::op_t          op,
  input  wire logic [1:0]            command,
  input  wire logic [ADDR_BITS-1:0]  address,
  input  wire logic [ADDR_BITS-PAGE_SHIFT:0] page_count,
  output ara_pkg::stat_t             st,
  output logic [1:0]                 status,
  output logic [ADDR_BITS-1:0]       found_address,
  output logic [ADDR_BITS-PAGE_SHIFT:0] freed_pages
);

  localparam int PAGE_W  = ADDR_BITS - PAGE_SHIFT;
  localparam int COUNT_W = PAGE_W + 1;
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W   = 1 + COUNT_W + PAGE_W;
  localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_SEGMENTS);
  localparam logic [ENT_W-1:0] RESET_ENT = {1'b0, 1'b1, {PAGE_W{1'b0}}, {PAGE_W{1'b0}}};

  // Segment table: {allocated, end page, start page}
  logic [ENT_W-1:0] mem [MAX_SEGMENTS];
  logic [ENT_W-1:0] rd_q;
  logic             rd_init;
  logic             ent0_ok;

  logic [1:0]         cmd_q;
  logic [PAGE_W-1:0]  sp;
  logic [PAGE_W+1:0]  ep;
  logic [COUNT_W-1:0] pages;
  logic [CNT_W-1:0]   i, j, lo, hi, cnt;
  logic [PAGE_W-1:0]  old_start, lo_start;
  logic [COUNT_W-1:0] old_end, hi_end;
  logic [1:0]         need;
  logic               left_q, right_q, early;

  logic [ENT_W-1:0]   ent;
  logic [PAGE_W-1:0]  e_start;
  logic [COUNT_W-1:0] e_end, e_len;
  logic               e_alloc;
  logic               t_left, t_right;
  logic [1:0]         need_c;
  logic [CNT_W-1:0]   removed, rd_full, wr_full;
  logic [ENT_W-1:0]   wr_data;
  logic               wr_en;
  logic               early_c;
  logic [1:0]         early_st;
  logic               aligned, pz;

  // Entry read last cycle, with the reset value for an unwritten entry 0
  assign ent     = rd_init ? RESET_ENT : rd_q;
  assign e_start = ent[PAGE_W-1:0];
  assign e_end   = ent[PAGE_W+COUNT_W-1:PAGE_W];
  assign e_alloc = ent[ENT_W-1];
  assign e_len   = e_end - {1'b0, e_start};
  assign t_left  = e_start < sp;
  assign t_right = {1'b0, e_end} > ep;
  assign need_c  = {1'b0, t_left} + {1'b0, t_right};
  assign removed = hi - lo;

  // Classify the request before any scan
  assign aligned = (address[PAGE_SHIFT-1:0] == '0);
  assign pz      = (page_count == '0);
  always_comb begin
    early_c  = 1'b0;
    early_st = ara_pkg::ST_MISS;
    case (command)
      ara_pkg::CMD_FIND: begin
        if (pz) begin
          early_c  = 1'b1;
          early_st = ara_pkg::ST_BAD;
        end
      end
      ara_pkg::CMD_TAKE: begin
        if (pz) begin
          early_c  = 1'b1;
          early_st = ara_pkg::ST_OK;
        end else if (!aligned) begin
          early_c  = 1'b1;
          early_st = ara_pkg::ST_BAD;
        end
      end
      ara_pkg::CMD_FREE: begin
        if (address == '0 || !aligned) begin
          early_c  = 1'b1;
          early_st = ara_pkg::ST_BAD;
        end
      end
      default: begin
        early_c  = 1'b1;
        early_st = ara_pkg::ST_BAD;
      end
    endcase
  end

  // Status flags
  always_comb begin
    st          = '0;
    st.early    = early;
    st.is_find  = (cmd_q == ara_pkg::CMD_FIND);
    st.is_take  = (cmd_q == ara_pkg::CMD_TAKE);
    st.is_free  = (cmd_q == ara_pkg::CMD_FREE);
    st.scan_end = (i >= cnt);
    case (cmd_q)
      ara_pkg::CMD_FIND: st.match = !e_alloc && (e_len >= pages);
      ara_pkg::CMD_TAKE: st.match = !e_alloc && (e_start <= sp) && ({1'b0, e_end} >= ep);
      ara_pkg::CMD_FREE: st.match = (e_start == sp);
      default:           st.match = 1'b0;
    endcase
    st.full     = ({1'b0, cnt} + (CNT_W + 1)'(need_c)) > MAX_CNT;
    st.sh_done  = (need == 2'd0) || (j <= i);
    st.left     = left_q;
    st.right    = right_q;
    st.lo_zero  = (lo == '0);
    st.hi_last  = ((hi + 1'b1) >= cnt);
    st.rd_alloc = e_alloc;
    st.mv_done  = (removed == '0) || (j >= cnt);
  end

  // Read address
  always_comb begin
    case (op)
      ara_pkg::OP_RD_J:  rd_full = j;
      ara_pkg::OP_RD_LO: rd_full = lo - 1'b1;
      ara_pkg::OP_RD_HI: rd_full = hi + 1'b1;
      default:           rd_full = i;
    endcase
  end

  // Write address and data
  always_comb begin
    wr_en   = 1'b1;
    wr_full = i;
    wr_data = ent;
    case (op)
      ara_pkg::OP_WR_SHIFT: begin
        wr_full = j + CNT_W'(need);
      end
      ara_pkg::OP_WR_LEFT: begin
        wr_data = {1'b0, {1'b0, sp}, old_start};
      end
      ara_pkg::OP_WR_MID: begin
        wr_full = i + CNT_W'(left_q);
        wr_data = {1'b1, ep[COUNT_W-1:0], sp};
      end
      ara_pkg::OP_WR_RIGHT: begin
        wr_full = i + CNT_W'(left_q) + 1'b1;
        wr_data = {1'b0, old_end, ep[PAGE_W-1:0]};
      end
      ara_pkg::OP_WR_MERGE: begin
        wr_full = lo;
        wr_data = {1'b0, hi_end, lo_start};
      end
      ara_pkg::OP_WR_MOVE: begin
        wr_full = j - removed;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_full[IDX_W-1:0]] <= wr_data;
    end
    rd_q <= mem[rd_full[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent0_ok <= 1'b0;
      rd_init <= 1'b0;
    end else begin
      rd_init <= (rd_full[IDX_W-1:0] == '0) && !ent0_ok;
      if (wr_en && wr_full[IDX_W-1:0] == '0) begin
        ent0_ok <= 1'b1;
      end
    end
  end

  // Request registers, indexes and results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= CNT_W'(1);
      early <= 1'b0;
      cmd_q <= ara_pkg::CMD_FIND;
    end else begin
      case (op)
        ara_pkg::OP_LOAD: begin
          cmd_q         <= command;
          sp            <= address[ADDR_BITS-1:PAGE_SHIFT];
          ep            <= {2'b00, address[ADDR_BITS-1:PAGE_SHIFT]} + {1'b0, page_count};
          pages         <= page_count;
          i             <= '0;
          early         <= early_c;
          status        <= early_st;
          found_address <= '0;
          freed_pages   <= '0;
        end
        ara_pkg::OP_NOTFOUND: status <= ara_pkg::ST_MISS;
        ara_pkg::OP_NEXT:     i <= i + 1'b1;
        ara_pkg::OP_FIND_HIT: begin
          found_address <= {e_start, {PAGE_SHIFT{1'b0}}};
          status        <= ara_pkg::ST_OK;
        end
        ara_pkg::OP_SET_FULL: status <= ara_pkg::ST_FULL;
        ara_pkg::OP_TAKE_HIT: begin
          old_start <= e_start;
          old_end   <= e_end;
          left_q    <= t_left;
          right_q   <= t_right;
          need      <= need_c;
          j         <= cnt - 1'b1;
          status    <= ara_pkg::ST_OK;
        end
        ara_pkg::OP_WR_SHIFT: j <= j - 1'b1;
        ara_pkg::OP_WR_MID:   cnt <= cnt + CNT_W'(need);
        ara_pkg::OP_FREE_HIT: begin
          freed_pages <= e_len;
          lo          <= i;
          hi          <= i;
          lo_start    <= e_start;
          hi_end      <= e_end;
          status      <= ara_pkg::ST_OK;
        end
        ara_pkg::OP_LO_DEC: begin
          lo       <= lo - 1'b1;
          lo_start <= e_start;
        end
        ara_pkg::OP_HI_INC: begin
          hi     <= hi + 1'b1;
          hi_end <= e_end;
        end
        ara_pkg::OP_WR_MERGE: j <= hi + 1'b1;
        ara_pkg::OP_WR_MOVE:  j <= j + 1'b1;
        ara_pkg::OP_FIN_FREE: cnt <= cnt - removed;
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && ({1'b0, cnt} <= MAX_CNT))
    else $error("segment count out of range");
  a_load_clear: assert property (@(posedge clk) disable iff (rst)
    (op == ara_pkg::OP_LOAD) |=> (found_address == '0) && (freed_pages == '0))
    else $error("results not cleared on load");
  a_shift_above: assert property (@(posedge clk) disable iff (rst)
    (op == ara_pkg::OP_WR_SHIFT) |-> (j > i))
    else $error("gap shift below the split entry");
  a_move_above: assert property (@(posedge clk) disable iff (rst)
    (op == ara_pkg::OP_WR_MOVE) |-> (j > hi) && (hi >= lo))
    else $error("merge move from inside the merged run");
`endif

endmodule
`default_nettype wire
